[rtl/core/i2a_pkg.sv]
package i2a_pkg;

  // width of the value that is converted, low bits of the input word
  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned NumberW = 64;

  // most characters of one conversion
  localparam int unsigned DIGIT_DEPTH = 20;
  localparam int unsigned DigitW = 4;
  localparam int unsigned BcdBits = DIGIT_DEPTH * DigitW;

  // double dabble handles four bits of the value per cycle
  localparam int unsigned StepsPerCycle = 4;
  localparam int unsigned DabbleIter = (VALUE_BITS + StepsPerCycle - 1) / StepsPerCycle;
  localparam int unsigned PadBits = DabbleIter * StepsPerCycle;
  localparam int unsigned IterCntW = $clog2(DabbleIter + 1);

  localparam int unsigned CharW = 8;
  localparam int unsigned LenW = 5;
  localparam int unsigned IdxW = $clog2(DIGIT_DEPTH);
  localparam int unsigned OutDataW = 16;

  typedef enum logic [1:0] {
    ACT_DEC       = 2'd0,
    ACT_HEX_LOWER = 2'd1,
    ACT_HEX_UPPER = 2'd2
  } action_e;

  // classified item, front to converter
  typedef struct packed {
    logic [PadBits-1:0] mag;
    logic               dec;
    logic               upper;
    logic               neg;
  } job_t;

  // finished digits, converter to emitter, least significant digit lowest
  typedef struct packed {
    logic [BcdBits-1:0] digits;
    logic               upper;
    logic               neg;
  } conv_res_t;

endpackage

[rtl/core/i2a_front.sv]
module i2a_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic [1:0]          action_i,
  input  logic [63:0]         number_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output i2a_pkg::job_t       q_data_o
);
  import i2a_pkg::*;

  localparam int unsigned QDepth = 2;

  job_t                  entries_q [QDepth];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            cnt_q;
  logic                  push, pop;
  job_t                  job;
  logic [VALUE_BITS-1:0] val;

  // classify: sign, magnitude, letter case
  always_comb begin
    val       = number_i[VALUE_BITS-1:0];
    job.dec   = (action_i == ACT_DEC);
    job.upper = (action_i != ACT_DEC) && (action_i != ACT_HEX_LOWER);
    job.neg   = job.dec && val[VALUE_BITS-1];
    // negation as unsigned keeps the most negative value exact
    job.mag   = PadBits'(job.neg ? (~val + VALUE_BITS'(1)) : val);
  end

  assign s_ready_o = (cnt_q != 2'(QDepth));
  assign push      = s_valid_i && s_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_pop_i && q_valid_o;
  assign q_data_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[rtl/core/i2a_conv.sv]
module i2a_conv (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  i2a_pkg::job_t        q_data_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output i2a_pkg::conv_res_t   res_o
);
  import i2a_pkg::*;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_RUN,
    CONV_HOLD
  } conv_state_e;

  localparam int unsigned ShW = BcdBits + PadBits;

  conv_state_e          state_q, state_d;
  logic [BcdBits-1:0]   bcd_q;
  logic [PadBits-1:0]   bin_q;
  logic [IterCntW-1:0]  cnt_q;
  logic                 upper_q, neg_q;
  logic [ShW-1:0]       sh;
  logic                 take;

  // four double dabble steps: add 3 to digits of 5 or more, then shift
  always_comb begin
    logic [DigitW-1:0] dig;
    sh = {bcd_q, bin_q};
    for (int s = 0; s < StepsPerCycle; s++) begin
      for (int d = 0; d < DIGIT_DEPTH; d++) begin
        dig = sh[PadBits + d*DigitW +: DigitW];
        if (dig >= 4'd5) sh[PadBits + d*DigitW +: DigitW] = dig + 4'd3;
      end
      sh = sh << 1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CONV_IDLE: if (q_valid_i) state_d = q_data_i.dec ? CONV_RUN : CONV_HOLD;
      CONV_RUN:  if (cnt_q == IterCntW'(1)) state_d = CONV_HOLD;
      CONV_HOLD: if (res_ready_i) state_d = CONV_IDLE;
      default:   state_d = CONV_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop_o     = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      CONV_IDLE: q_pop_o     = 1'b1;
      CONV_HOLD: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign take         = q_pop_o && q_valid_i;
  assign res_o.digits = bcd_q;
  assign res_o.upper  = upper_q;
  assign res_o.neg    = neg_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      upper_q <= q_data_i.upper;
      neg_q   <= q_data_i.neg;
      bin_q   <= q_data_i.mag;
      cnt_q   <= IterCntW'(DabbleIter);
      // hex digits are the nibbles of the magnitude
      bcd_q   <= q_data_i.dec ? '0 : BcdBits'(q_data_i.mag);
    end else if (state_q == CONV_RUN) begin
      bcd_q <= sh[ShW-1:PadBits];
      bin_q <= sh[PadBits-1:0];
      cnt_q <= cnt_q - IterCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CONV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/i2a_emit.sv]
module i2a_emit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    res_valid_i,
  output logic                    res_ready_o,
  input  i2a_pkg::conv_res_t      res_i,
  output logic                    m_valid_o,
  input  logic                    m_ready_i,
  output logic [7:0]              character_o,
  output logic [4:0]              total_length_o,
  output logic                    last_o
);
  import i2a_pkg::*;

  localparam logic [CharW-1:0] CharZero   = 8'h30;
  localparam logic [CharW-1:0] CharMinus  = 8'h2D;
  localparam logic [CharW-1:0] CharUpperA = 8'h41;
  localparam logic [CharW-1:0] CharLowerA = 8'h61;

  logic [DigitW-1:0] digits_q [DIGIT_DEPTH];
  logic              busy_q, neg_pend_q, upper_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic [LenW-1:0]   remain_q, total_q;
  logic              out_valid_q, out_last_q;
  logic [CharW-1:0]  out_char_q;
  logic [LenW-1:0]   out_len_q;

  logic              take, slot_free, load_char;
  logic [LenW-1:0]   ndig, total;
  logic [DigitW-1:0] cur_dig;
  logic [CharW-1:0]  cur_char;

  // digit count of the new run and its length with the sign
  always_comb begin
    ndig = LenW'(1);
    for (int i = 1; i < DIGIT_DEPTH; i++) begin
      if (res_i.digits[i*DigitW +: DigitW] != '0) ndig = LenW'(i + 1);
    end
    total = ndig + LenW'(res_i.neg);
    if (total > LenW'(DIGIT_DEPTH)) total = LenW'(DIGIT_DEPTH);
  end

  always_comb begin
    cur_dig = digits_q[rd_idx_q];
    if (neg_pend_q) begin
      cur_char = CharMinus;
    end else if (cur_dig <= 4'd9) begin
      cur_char = CharZero + CharW'(cur_dig);
    end else begin
      cur_char = (upper_q ? CharUpperA : CharLowerA) + CharW'(cur_dig - 4'd10);
    end
  end

  assign res_ready_o = !busy_q;
  assign take        = res_valid_i && !busy_q;
  assign slot_free   = !out_valid_q || m_ready_i;
  assign load_char   = busy_q && slot_free;

  assign m_valid_o      = out_valid_q;
  assign character_o    = out_char_q;
  assign total_length_o = out_len_q;
  assign last_o         = out_last_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int i = 0; i < DIGIT_DEPTH; i++) begin
        digits_q[i] <= res_i.digits[i*DigitW +: DigitW];
      end
      upper_q <= res_i.upper;
      total_q <= total;
    end
    if (load_char) begin
      out_char_q <= cur_char;
      out_len_q  <= total_q;
      out_last_q <= (remain_q == LenW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      neg_pend_q  <= 1'b0;
      rd_idx_q    <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        busy_q     <= 1'b1;
        neg_pend_q <= res_i.neg;
        rd_idx_q   <= IdxW'(ndig - LenW'(1));
        remain_q   <= total;
      end else if (load_char) begin
        if (neg_pend_q) neg_pend_q <= 1'b0;
        else            rd_idx_q   <= rd_idx_q - IdxW'(1);
        remain_q <= remain_q - LenW'(1);
        if (remain_q == LenW'(1)) busy_q <= 1'b0;
      end
      if (load_char)      out_valid_q <= 1'b1;
      else if (m_ready_i) out_valid_q <= 1'b0;
    end
  end

  a_busy_has_chars : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (remain_q != '0) && (remain_q <= total_q))
    else $error("run busy without characters left");

  a_digit_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !neg_pend_q) |-> (remain_q == LenW'(rd_idx_q) + LenW'(1)))
    else $error("digit index out of step with characters left");

  a_last_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_char && (remain_q == LenW'(1))) |=> (!busy_q && out_valid_q && out_last_q))
    else $error("final character did not end the run");

endmodule

[rtl/core/integer_to_ascii_formatter.sv]
// integer to ascii formatter
// takes a 64-bit value and a mode on the slave stream and sends its text, one ascii
// character per transfer, most significant first, on the master stream
// s_axis: tdata carries the value, tuser the mode (0 signed decimal, 1 lowercase hex,
//   2 or 3 uppercase hex); a transfer is taken while the two-entry input queue has room
// m_axis: tdata carries the character and the run length, tlast flags the final character
// no leading zeros; zero gives a single '0'; decimal negatives get a leading '-'
// the path to the first character runs through the queue, 16 double dabble passes of four bits
//   each in decimal (none in hex), the hand-off and the output register
// throughput: the emitter loads each run and then sends one character per cycle while the
//   receiver is ready; conversion of the next item overlaps the current run
// reset clears queue pointers, converter state and output valid; nothing is emitted
// while the receiver stalls, the output register holds its character and the emitter,
//   converter and input queue fill up in turn before tready drops
module integer_to_ascii_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] number
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] character, [12:8] total_length, [15:13] zero
  output logic        m_axis_tlast    // last
);
  import i2a_pkg::*;

  job_t       q_data;
  logic       q_valid, q_pop;
  conv_res_t  res;
  logic       res_valid, res_ready;
  logic [7:0] character;
  logic [4:0] total_length;

  // front: classify and queue
  i2a_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .action_i  (s_axis_tuser),
    .number_i  (s_axis_tdata),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_data_o  (q_data)
  );

  // back: digit extraction
  i2a_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // back: character emission
  i2a_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_valid_i    (res_valid),
    .res_ready_o    (res_ready),
    .res_i          (res),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .character_o    (character),
    .total_length_o (total_length),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, total_length, character};

endmodule
